### hw/rtl/gnpf_pkg.sv
// Shared constants and types of the grid null-point finder.
package gnpf_pkg;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int ROW_W = $clog2(GRID_ROWS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DET_THRESHOLD = 2'd0,
    REG_MAX_NULLS     = 2'd1
  } cfg_reg_t;

  localparam logic KIND_OPOINT = 1'b0;
  localparam logic KIND_XPOINT = 1'b1;

  // Window of 4x4 vertices, each limiter bit over Q16.16 flux.
  typedef logic [15:0][32:0] win_t;

  typedef struct packed {
    logic             we;
    logic [COL_W-1:0] col;
    logic [1:0]       bank;
    logic [32:0]      data;
  } lb_wr_t;

  typedef struct packed {
    logic        start;
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
    logic [31:0] det_threshold;
  } fit_cmd_t;

  typedef struct packed {
    logic        found;
    logic        kind;
    logic [23:0] col_pos;
    logic [23:0] row_pos;
    logic [31:0] flux;
  } fit_res_t;

endpackage

### hw/rtl/gnpf_if.sv
// Sample and result channel interfaces of the grid null-point finder.
interface gnpf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] flux_sample;
  logic               in_limiter;
  logic               frame_start;

  modport source (output valid, flux_sample, in_limiter, frame_start, input ready);
  modport sink (input valid, flux_sample, in_limiter, frame_start, output ready);
endinterface

interface gnpf_out_if;
  logic               valid;
  logic               ready;
  logic               null_kind;
  logic [23:0]        col_pos;
  logic [23:0]        row_pos;
  logic signed [31:0] null_flux;
  logic [7:0]         null_index;
  logic               overflow;

  modport source (output valid, null_kind, col_pos, row_pos, null_flux, null_index,
                  overflow, input ready);
  modport sink (input valid, null_kind, col_pos, row_pos, null_flux, null_index,
                overflow, output ready);
endinterface

### hw/rtl/gnpf_linebuf.sv
// Three banked line stores and the 4x4 vertex window.
module gnpf_linebuf (
  input  logic            clk,
  input  gnpf_pkg::lb_wr_t wr,
  input  logic            shift,
  output gnpf_pkg::win_t  win
);
  import gnpf_pkg::*;

  logic [32:0] mem0 [GRID_COLS];
  logic [32:0] mem1 [GRID_COLS];
  logic [32:0] mem2 [GRID_COLS];
  logic [32:0] rd0_r, rd1_r, rd2_r;
  logic [32:0] nv_r;
  logic [1:0]  rbank_r;
  logic [1:0]  bank1, bank2;
  win_t        win_r;

  function automatic logic [32:0] pick(logic [1:0] b, logic [32:0] d0, logic [32:0] d1,
                                       logic [32:0] d2);
    logic [32:0] v;
    case (b)
      2'd0:    v = d0;
      2'd1:    v = d1;
      default: v = d2;
    endcase
    return v;
  endfunction

  // Each bank is read at the column being written; the read sees the old row.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      if (wr.bank == 2'd0) mem0[wr.col] <= wr.data;
      if (wr.bank == 2'd1) mem1[wr.col] <= wr.data;
      if (wr.bank == 2'd2) mem2[wr.col] <= wr.data;
      rd0_r   <= mem0[wr.col];
      rd1_r   <= mem1[wr.col];
      rd2_r   <= mem2[wr.col];
      nv_r    <= wr.data;
      rbank_r <= wr.bank;
    end
  end

  assign bank1 = (rbank_r == 2'd2) ? 2'd0 : rbank_r + 2'd1;
  assign bank2 = (bank1 == 2'd2) ? 2'd0 : bank1 + 2'd1;

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int k = 0; k < 4; k++) begin
        win_r[k*4+0] <= win_r[k*4+1];
        win_r[k*4+1] <= win_r[k*4+2];
        win_r[k*4+2] <= win_r[k*4+3];
      end
      win_r[3]  <= pick(rbank_r, rd0_r, rd1_r, rd2_r);
      win_r[7]  <= pick(bank1, rd0_r, rd1_r, rd2_r);
      win_r[11] <= pick(bank2, rd0_r, rd1_r, rd2_r);
      win_r[15] <= nv_r;
    end
  end

  assign win = win_r;

endmodule

### hw/rtl/gnpf_fit.sv
// Corner fit engine: one shared multiplier, an accumulator and a bit-serial divider.
module gnpf_fit (
  input  logic               clk,
  input  logic               rst_n,
  input  gnpf_pkg::win_t     win,
  input  gnpf_pkg::fit_cmd_t cmd,
  output logic               done,
  output gnpf_pkg::fit_res_t res
);
  import gnpf_pkg::*;

  localparam int AW = 80;
  localparam int MW = 36;
  localparam int PW = 2 * MW;
  localparam int DW = 90;

  typedef enum logic [3:0] {
    F_IDLE, F_LOAD, F_MUL, F_ACC, F_NEG, F_CHECK, F_DSET, F_DIV, F_RND, F_FIN, F_DONE
  } fstate_t;

  fstate_t state_r;
  logic [1:0] corner_r;
  logic [3:0] step_r;
  logic signed [31:0] f0_r;
  logic signed [32:0] a2_r, b2_r;
  logic signed [34:0] c_r, d_r, e4_r;
  logic signed [PW-1:0] p_r;
  logic signed [AW-1:0] acc_r, h_r, nr_r, nz_r;
  logic signed [MW-1:0] sq_r;
  logic [33:0] dist_r, best_d_r;
  logic kind_r, div_sel_r, neg_r;
  logic [DW-1:0] rem_r, t_r;
  logic [17:0] q_r;
  logic [4:0] bit_r;
  logic signed [17:0] dq_r, zq_r;
  logic signed [45:0] s_r;
  logic found_r, best_kind_r;
  logic [23:0] best_col_r, best_row_r;
  logic [31:0] best_flux_r;

  logic [1:0] wr, wc;
  logic dc, dw, last_corner, lim;
  logic signed [31:0] fc, fr, fl, fu, fd, fpp, fpm, fmp, fmm;
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] pe, ux, uz, num, acc_rnd;
  logic [AW-1:0] mag, thr_ext;
  logic thr_ok, in_x, in_z, ge, better;
  logic [17:0] q_nxt, off;
  logic signed [17:0] qs;
  logic [31:0] flux_sat;
  logic [23:0] pos_c, pos_r;

  function automatic logic signed [31:0] fx(win_t w, logic [1:0] rr, logic [1:0] cc);
    return signed'(w[{rr, cc}][31:0]);
  endfunction

  assign dc = corner_r[0];
  assign dw = corner_r[1];
  assign wr = 2'd1 + {1'b0, dw};
  assign wc = 2'd1 + {1'b0, dc};
  assign last_corner = (corner_r == 2'd3);
  assign lim = win[{wr, wc}][32];

  always_comb begin
    fc  = fx(win, wr, wc);
    fr  = fx(win, wr, wc + 2'd1);
    fl  = fx(win, wr, wc - 2'd1);
    fu  = fx(win, wr + 2'd1, wc);
    fd  = fx(win, wr - 2'd1, wc);
    fpp = fx(win, wr + 2'd1, wc + 2'd1);
    fpm = fx(win, wr + 2'd1, wc - 2'd1);
    fmp = fx(win, wr - 2'd1, wc + 2'd1);
    fmm = fx(win, wr - 2'd1, wc - 2'd1);
  end

  // Operand schedule of the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (step_r)
      4'd0:  begin ma = MW'(c_r);  mb = MW'(d_r);  end
      4'd1:  begin ma = MW'(e4_r); mb = MW'(e4_r); end
      4'd2:  begin ma = MW'(b2_r); mb = MW'(e4_r); end
      4'd3:  begin ma = MW'(a2_r); mb = MW'(d_r);  end
      4'd4:  begin ma = MW'(a2_r); mb = MW'(e4_r); end
      4'd5:  begin ma = MW'(b2_r); mb = MW'(c_r);  end
      4'd6:  begin ma = MW'(dq_r); mb = MW'(dq_r); end
      4'd7:  begin ma = MW'(c_r);  mb = sq_r;      end
      4'd8:  begin ma = MW'(zq_r); mb = MW'(zq_r); end
      4'd9:  begin ma = MW'(d_r);  mb = sq_r;      end
      4'd10: begin ma = MW'(dq_r); mb = MW'(zq_r); end
      4'd11: begin ma = MW'(e4_r); mb = sq_r;      end
      4'd12: begin ma = MW'(a2_r); mb = MW'(dq_r); end
      4'd13: begin ma = MW'(b2_r); mb = MW'(zq_r); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = ma * mb;
  assign pe   = AW'(p_r);

  always_comb begin
    thr_ext = {28'd0, cmd.det_threshold, 20'd0};
    thr_ok  = $unsigned(h_r) >= thr_ext;
    ux      = dc ? h_r + nr_r : nr_r;
    uz      = dw ? h_r + nz_r : nz_r;
    in_x    = !ux[AW-1] && (ux <= h_r);
    in_z    = !uz[AW-1] && (uz <= h_r);
    num     = div_sel_r ? nz_r : nr_r;
    mag     = num[AW-1] ? $unsigned(-num) : $unsigned(num);
    ge      = rem_r >= t_r;
    q_nxt   = ge ? (q_r | (18'd1 << bit_r)) : q_r;
    off     = (q_nxt + 18'd1) >> 1;
    qs      = neg_r ? -signed'(off) : signed'(off);
    acc_rnd = acc_r + (AW'(1) <<< 33);
    if (s_r > 46'sd2147483647) flux_sat = 32'h7fff_ffff;
    else if (s_r < -46'sd2147483648) flux_sat = 32'h8000_0000;
    else flux_sat = s_r[31:0];
    better  = !found_r || (dist_r < best_d_r);
    pos_c   = {cmd.cell_col + {7'd0, dc}, 16'd0} + 24'(dq_r);
    pos_r   = {cmd.cell_row + {7'd0, dw}, 16'd0} + 24'(zq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      corner_r <= 2'd0;
      step_r   <= 4'd0;
      found_r  <= 1'b0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (cmd.start) begin
            corner_r <= 2'd0;
            found_r  <= 1'b0;
            state_r  <= F_LOAD;
          end
        end
        F_LOAD: begin
          f0_r   <= fc;
          a2_r   <= 33'(fr) - 33'(fl);
          b2_r   <= 33'(fu) - 33'(fd);
          c_r    <= 35'(fr) + 35'(fl) - (35'(fc) <<< 1);
          d_r    <= 35'(fu) + 35'(fd) - (35'(fc) <<< 1);
          e4_r   <= 35'(fpp) - 35'(fpm) - 35'(fmp) + 35'(fmm);
          step_r <= 4'd0;
          if (lim) begin
            state_r <= F_MUL;
          end else begin
            corner_r <= corner_r + 2'd1;
            state_r  <= last_corner ? F_DONE : F_LOAD;
          end
        end
        F_MUL: begin
          p_r     <= prod;
          state_r <= F_ACC;
        end
        F_ACC: begin
          step_r <= step_r + 4'd1;
          if (step_r == 4'd5) state_r <= F_NEG;
          else if (step_r == 4'd13) state_r <= F_RND;
          else state_r <= F_MUL;
          case (step_r)
            4'd0: acc_r <= pe <<< 4;
            4'd1: h_r <= acc_r - pe;
            4'd2: acc_r <= pe <<< 1;
            4'd3: nr_r <= acc_r - (pe <<< 3);
            4'd4: acc_r <= pe <<< 1;
            4'd5: nz_r <= acc_r - (pe <<< 3);
            4'd6: begin
              sq_r   <= p_r[MW-1:0];
              dist_r <= p_r[33:0];
            end
            4'd7: acc_r <= (AW'(f0_r) <<< 34) + (pe <<< 1);
            4'd8: begin
              sq_r   <= p_r[MW-1:0];
              dist_r <= dist_r + p_r[33:0];
            end
            4'd9:  acc_r <= acc_r + (pe <<< 1);
            4'd10: sq_r <= p_r[MW-1:0];
            4'd11: acc_r <= acc_r + pe;
            4'd12: acc_r <= acc_r + (pe <<< 17);
            default: acc_r <= acc_r + (pe <<< 17);
          endcase
        end
        F_NEG: begin
          // A singular Hessian never gives a null, whatever the threshold.
          if (h_r == '0) begin
            corner_r <= corner_r + 2'd1;
            state_r  <= last_corner ? F_DONE : F_LOAD;
          end else begin
            kind_r <= h_r[AW-1];
            if (h_r[AW-1]) begin
              h_r  <= -h_r;
              nr_r <= -nr_r;
              nz_r <= -nz_r;
            end
            state_r <= F_CHECK;
          end
        end
        F_CHECK: begin
          div_sel_r <= 1'b0;
          if (thr_ok && in_x && in_z) begin
            state_r <= F_DSET;
          end else begin
            corner_r <= corner_r + 2'd1;
            state_r  <= last_corner ? F_DONE : F_LOAD;
          end
        end
        F_DSET: begin
          neg_r   <= num[AW-1];
          rem_r   <= DW'(mag) << 17;
          t_r     <= DW'($unsigned(h_r)) << 17;
          q_r     <= 18'd0;
          bit_r   <= 5'd17;
          state_r <= F_DIV;
        end
        F_DIV: begin
          if (ge) rem_r <= rem_r - t_r;
          q_r   <= q_nxt;
          t_r   <= t_r >> 1;
          bit_r <= bit_r - 5'd1;
          if (bit_r == 5'd0) begin
            if (!div_sel_r) begin
              dq_r      <= qs;
              div_sel_r <= 1'b1;
              state_r   <= F_DSET;
            end else begin
              zq_r    <= qs;
              step_r  <= 4'd6;
              state_r <= F_MUL;
            end
          end
        end
        F_RND: begin
          s_r     <= 46'(acc_rnd >>> 34);
          state_r <= F_FIN;
        end
        F_FIN: begin
          if (better) begin
            found_r     <= 1'b1;
            best_d_r    <= dist_r;
            best_kind_r <= kind_r;
            best_col_r  <= pos_c;
            best_row_r  <= pos_r;
            best_flux_r <= flux_sat;
          end
          corner_r <= corner_r + 2'd1;
          state_r  <= last_corner ? F_DONE : F_LOAD;
        end
        F_DONE: state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign done        = (state_r == F_DONE);
  assign res.found   = found_r;
  assign res.kind    = best_kind_r;
  assign res.col_pos = best_col_r;
  assign res.row_pos = best_row_r;
  assign res.flux    = best_flux_r;

endmodule

### hw/rtl/grid_null_point_finder.sv
// Top level of the grid null-point finder: raster control, counters and result register.
// An item that completes no cell passes through the shift state only; one that completes a
// cell also starts the fit engine, and the emit state follows when a result is found. The
// fit engine skips each corner outside the limiter after loading it and runs each fitted
// corner through the shared 36x36 multiplier and the one-bit-a-cycle divider. A result still
// waiting in the output register stalls only the emit state; the next item is taken while it waits.
// Synchronous reset clears control state and sets det_threshold to 1, max_nulls to 16.
module grid_null_point_finder (
  input  logic                             clk,
  input  logic                             rst_n,
  gnpf_in_if.sink                          in_ch,
  gnpf_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [gnpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gnpf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gnpf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_FIT, S_EMIT} state_t;

  state_t state_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [1:0] bank_r;
  logic [7:0] opc_r, xpc_r;
  logic halted_r, need_fit_r;
  logic [31:0] thr_r;
  logic [7:0] maxn_r;
  logic [7:0] cell_c_r, cell_r_r;
  logic out_valid_r, out_kind_r, out_ovf_r;
  logic [23:0] out_col_r, out_row_r;
  logic [31:0] out_flux_r;
  logic [7:0] out_idx_r;

  logic in_acc, fs, halted_e, col_last, row_last, emit_go, fit_done;
  logic [COL_W-1:0] col_e;
  logic [ROW_W-1:0] row_e;
  logic [1:0] bank_e;
  logic [7:0] cnt, cnt_n;
  lb_wr_t lb_wr;
  win_t win;
  fit_cmd_t fit_cmd;
  fit_res_t fit_res;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign fs       = in_ch.frame_start;
  assign col_e    = fs ? '0 : col_r;
  assign row_e    = fs ? '0 : row_r;
  assign bank_e   = fs ? 2'd0 : bank_r;
  assign halted_e = fs ? 1'b0 : halted_r;
  assign col_last = (col_e == COL_W'(GRID_COLS - 1));
  assign row_last = (row_e == ROW_W'(GRID_ROWS - 1));

  assign lb_wr.we   = in_acc && !halted_e;
  assign lb_wr.col  = col_e;
  assign lb_wr.bank = bank_e;
  assign lb_wr.data = {in_ch.in_limiter, in_ch.flux_sample};

  assign fit_cmd.start         = (state_r == S_SHIFT) && need_fit_r;
  assign fit_cmd.cell_col      = cell_c_r;
  assign fit_cmd.cell_row      = cell_r_r;
  assign fit_cmd.det_threshold = thr_r;

  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign cnt     = fit_res.kind ? xpc_r : opc_r;
  assign cnt_n   = cnt + 8'd1;

  gnpf_linebuf u_linebuf (
    .clk   (clk),
    .wr    (lb_wr),
    .shift (state_r == S_SHIFT),
    .win   (win)
  );

  gnpf_fit u_fit (
    .clk   (clk),
    .rst_n (rst_n),
    .win   (win),
    .cmd   (fit_cmd),
    .done  (fit_done),
    .res   (fit_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      bank_r      <= 2'd0;
      opc_r       <= 8'd0;
      xpc_r       <= 8'd0;
      halted_r    <= 1'b0;
      need_fit_r  <= 1'b0;
      thr_r       <= 32'd1;
      maxn_r      <= 8'd16;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DET_THRESHOLD: thr_r  <= cfg_wdata;
          REG_MAX_NULLS:     maxn_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready && !emit_go) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            // The column restarts below, since a frame start is never halted.
            if (fs) begin
              opc_r    <= 8'd0;
              xpc_r    <= 8'd0;
              halted_r <= 1'b0;
              row_r    <= '0;
              bank_r   <= 2'd0;
            end
            // A halted frame drops items until the next frame start.
            if (!halted_e) begin
              need_fit_r <= (col_e >= COL_W'(3)) && (row_e >= ROW_W'(3));
              cell_c_r   <= 8'(col_e) - 8'd2;
              cell_r_r   <= 8'(row_e) - 8'd2;
              col_r      <= col_last ? '0 : col_e + COL_W'(1);
              if (col_last) begin
                row_r    <= row_last ? '0 : row_e + ROW_W'(1);
                bank_r   <= (row_last || bank_e == 2'd2) ? 2'd0 : bank_e + 2'd1;
                halted_r <= row_last;
              end
              state_r <= S_SHIFT;
            end
          end
        end
        S_SHIFT: state_r <= need_fit_r ? S_FIT : S_IDLE;
        S_FIT: begin
          if (fit_done) state_r <= fit_res.found ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= fit_res.kind;
            out_col_r   <= fit_res.col_pos;
            out_row_r   <= fit_res.row_pos;
            out_flux_r  <= fit_res.flux;
            out_idx_r   <= cnt;
            out_ovf_r   <= (cnt_n >= maxn_r);
            if (fit_res.kind == KIND_XPOINT) xpc_r <= cnt_n;
            else opc_r <= cnt_n;
            if (cnt_n >= maxn_r) halted_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.null_kind  = out_kind_r;
  assign out_ch.col_pos    = out_col_r;
  assign out_ch.row_pos    = out_row_r;
  assign out_ch.null_flux  = out_flux_r;
  assign out_ch.null_index = out_idx_r;
  assign out_ch.overflow   = out_ovf_r;

endmodule

### hw/rtl/gnpf_checker.sv
// Port-level checks of the grid null-point finder and their binding.
module gnpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_flux
);

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("block not ready after reset");

  // A new result is only loaded while the block is busy with an item.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was idle");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flux))
    else $error("stalled result changed");

endmodule

bind grid_null_point_finder gnpf_checker u_gnpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_flux  (out_ch.null_flux)
);
